/* rtl/core/rfb_pkg.sv */
// Shared types, bus codes, band limits and helpers for the frequency frame decoder.
`default_nettype none

package rfb_pkg;

	localparam int BYTE_W    = 8;
	localparam int FREQ_W    = 34;
	localparam int BAND_W    = 4;
	localparam int NUM_BANDS = 13;
	localparam int NUM_DATA  = 5;
	localparam int POS_W     = $clog2(NUM_DATA);
	localparam int PAIR_W    = 7;
	localparam int SCALE_W   = 27;

	// Frame delimiters
	localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hFE;
	localparam logic [BYTE_W-1:0] END_BYTE      = 8'hFD;

	// Controller addresses
	localparam logic [BYTE_W-1:0] ADDR_CTRL_E1  = 8'hE1;
	localparam logic [BYTE_W-1:0] ADDR_CTRL_E0  = 8'hE0;
	localparam logic [BYTE_W-1:0] ADDR_CTRL_00  = 8'h00;
	localparam logic [BYTE_W-1:0] ADDR_CTRL_F1  = 8'hF1;

	// Radio addresses
	localparam logic [BYTE_W-1:0] ADDR_RADIO_A4 = 8'hA4;
	localparam logic [BYTE_W-1:0] ADDR_RADIO_94 = 8'h94;
	localparam logic [BYTE_W-1:0] ADDR_RADIO_B6 = 8'hB6;
	localparam logic [BYTE_W-1:0] ADDR_RADIO_98 = 8'h98;
	localparam logic [BYTE_W-1:0] ADDR_RADIO_96 = 8'h96;

	// Commands
	localparam logic [BYTE_W-1:0] CMD_FREQ_XFER = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_FREQ_BCST = 8'h03;
	localparam logic [BYTE_W-1:0] CMD_FREQ_SET  = 8'h05;

	localparam logic [BAND_W-1:0] BAND_NONE = 4'd15;

	// Weight of each data byte, least significant byte first
	localparam logic [SCALE_W-1:0] DIGIT_SCALE [NUM_DATA] = '{
		27'd1, 27'd100, 27'd10000, 27'd1000000, 27'd100000000
	};

	// Band limits in Hz, checked in this order
	localparam logic [FREQ_W-1:0] BAND_LOW [NUM_BANDS] = '{
		34'd5300000,  34'd1800000,  34'd3500000,  34'd7000000,  34'd10100000,
		34'd14000000, 34'd18068000, 34'd21000000, 34'd24890000, 34'd28000000,
		34'd50000000, 34'd144000000, 34'd420000000
	};
	localparam logic [FREQ_W-1:0] BAND_HIGH [NUM_BANDS] = '{
		34'd5450000,  34'd2000000,  34'd4000000,  34'd7300000,  34'd10150000,
		34'd14350000, 34'd18168000, 34'd21450000, 34'd24990000, 34'd29700000,
		34'd52000000, 34'd148000000, 34'd450000000
	};

	// Frame phase, one-hot
	typedef enum logic [12:0] {
		PH_PRE1 = 13'b0000000000001,
		PH_PRE2 = 13'b0000000000010,
		PH_DEST = 13'b0000000000100,
		PH_CSRC = 13'b0000000001000,
		PH_CCMD = 13'b0000000010000,
		PH_RSRC = 13'b0000000100000,
		PH_RCMD = 13'b0000001000000,
		PH_D0   = 13'b0000010000000,
		PH_D1   = 13'b0000100000000,
		PH_D2   = 13'b0001000000000,
		PH_D3   = 13'b0010000000000,
		PH_D4   = 13'b0100000000000,
		PH_END  = 13'b1000000000000
	} phase_t;

	function automatic logic is_ctrl(input logic [BYTE_W-1:0] b);
		return (b == ADDR_CTRL_E1) || (b == ADDR_CTRL_E0) ||
			(b == ADDR_CTRL_00) || (b == ADDR_CTRL_F1);
	endfunction

	function automatic logic is_radio(input logic [BYTE_W-1:0] b);
		return (b == ADDR_RADIO_A4) || (b == ADDR_RADIO_94) || (b == ADDR_RADIO_B6) ||
			(b == ADDR_RADIO_98) || (b == ADDR_RADIO_96);
	endfunction

	function automatic logic is_bcd(input logic [BYTE_W-1:0] b);
		return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
	endfunction

endpackage

`default_nettype wire

/* rtl/core/radio_freq_frame_band_decoder.sv */
// Frequency frame decoder: frame tracking, BCD to binary, band lookup and held band code.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   rx_byte[7:0]
// out      output     out_valid/out_stall frame_done, frequency_hz[33:0], band_found,
//                                         band_number[3:0], band_lines[3:0]
//
// One result per byte, via byte and result registers; one byte per cycle while out_stall is low.
// The byte register feeds the frame logic and the result register in one pass; each data
// byte is weighted and added into a running binary sum, so the whole frequency is ready
// at the end byte. Reset puts the frame in the first-preamble phase and the band code at 15.
// A stalled result holds; the byte register takes one more item behind it, then in_stall rises.
`default_nettype none

module radio_freq_frame_band_decoder
	import rfb_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [BYTE_W-1:0]   rx_byte,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic                frame_done,
	output      logic [FREQ_W-1:0]   frequency_hz,
	output      logic                band_found,
	output      logic [BAND_W-1:0]   band_number,
	output      logic [BAND_W-1:0]   band_lines
);

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	phase_t              phase_q, phase_d;
	logic [FREQ_W-1:0]   acc_q, acc_d;
	logic [BAND_W-1:0]   held_q, held_d;
	logic                out_free, proc;
	logic                done;
	logic [POS_W-1:0]    pos;
	logic [PAIR_W-1:0]   pair;
	logic [FREQ_W-1:0]   weighted;
	logic [NUM_BANDS-1:0] hit;
	logic                found;
	logic [BAND_W-1:0]   num;

	// Handshake: result register frees up or is empty, byte register moves on
	assign out_free = !out_valid || !out_stall;
	assign proc     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// Byte register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	// Select the weight of the current data byte
	always_comb begin
		unique case (phase_q)
			PH_D1:   pos = POS_W'(1);
			PH_D2:   pos = POS_W'(2);
			PH_D3:   pos = POS_W'(3);
			PH_D4:   pos = POS_W'(4);
			default: pos = POS_W'(0);
		endcase
	end

	// Two BCD digits to 0..99, then scale by the byte weight
	assign pair     = PAIR_W'({3'b000, byte_s1[7:4]}) * PAIR_W'(10)
		+ PAIR_W'({3'b000, byte_s1[3:0]});
	assign weighted = FREQ_W'(pair) * FREQ_W'(DIGIT_SCALE[pos]);

	// Advance the frame phase and the running sum
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		done    = 1'b0;
		priority if (byte_s1 == PREAMBLE_BYTE && phase_q != PH_PRE1 && phase_q != PH_PRE2) begin
			phase_d = PH_PRE2;
		end else begin
			unique case (phase_q)
				PH_PRE1: phase_d = (byte_s1 == PREAMBLE_BYTE) ? PH_PRE2 : PH_PRE1;
				PH_PRE2: phase_d = (byte_s1 == PREAMBLE_BYTE) ? PH_DEST : PH_PRE1;
				PH_DEST: begin
					if (is_ctrl(byte_s1)) phase_d = PH_CSRC;
					else if (is_radio(byte_s1)) phase_d = PH_RSRC;
					else phase_d = PH_PRE1;
				end
				PH_CSRC: phase_d = is_radio(byte_s1) ? PH_CCMD : PH_PRE1;
				PH_CCMD: phase_d = (byte_s1 == CMD_FREQ_XFER || byte_s1 == CMD_FREQ_BCST)
					? PH_D0 : PH_PRE1;
				PH_RSRC: phase_d = (byte_s1 == ADDR_CTRL_00 || byte_s1 == ADDR_CTRL_E0 ||
					byte_s1 == ADDR_CTRL_F1) ? PH_RCMD : PH_PRE1;
				PH_RCMD: phase_d = (byte_s1 == CMD_FREQ_XFER || byte_s1 == CMD_FREQ_SET)
					? PH_D0 : PH_PRE1;
				PH_D0, PH_D1, PH_D2, PH_D3, PH_D4: begin
					if (is_bcd(byte_s1)) begin
						acc_d = ((phase_q == PH_D0) ? '0 : acc_q) + weighted;
						unique case (phase_q)
							PH_D0:   phase_d = PH_D1;
							PH_D1:   phase_d = PH_D2;
							PH_D2:   phase_d = PH_D3;
							PH_D3:   phase_d = PH_D4;
							default: phase_d = PH_END;
						endcase
					end else begin
						phase_d = PH_PRE1;
					end
				end
				PH_END: begin
					phase_d = PH_PRE1;
					done    = (byte_s1 == END_BYTE);
				end
				default: phase_d = PH_PRE1;
			endcase
		end
	end

	// Compare the finished frequency against every band
	always_comb begin
		for (int i = 0; i < NUM_BANDS; i++) begin
			hit[i] = (acc_q >= BAND_LOW[i]) && (acc_q <= BAND_HIGH[i]);
		end
	end

	// Pick the first matching band
	always_comb begin
		num = '0;
		for (int i = NUM_BANDS - 1; i >= 0; i--) begin
			if (hit[i]) num = BAND_W'(i);
		end
	end

	assign found  = done && (|hit);
	assign held_d = found ? num : held_q;

	// Frame state and held band code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PRE1;
			held_q  <= BAND_NONE;
		end else if (proc) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			acc_q <= acc_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			frame_done   <= done;
			frequency_hz <= done ? acc_q : '0;
			band_found   <= found;
			band_number  <= found ? num : '0;
			band_lines   <= held_d;
		end
	end

endmodule

`default_nettype wire
